/* design/wrr_pkg.sv */
// Shared constants, types and helpers for the weighted round-robin class queues.
// Used by weighted_round_robin_class_queues_core; no dependencies.
package wrr_pkg;

    localparam int NUM_CLASSES = 5;
    localparam int QUEUE_DEPTH = 64;

    localparam int SLOT_W      = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int CLS_W       = $clog2(NUM_CLASSES);
    localparam int MEM_DEPTH   = NUM_CLASSES * QUEUE_DEPTH;
    localparam int ADDR_W      = $clog2(MEM_DEPTH);
    localparam int TOT_W       = $clog2(MEM_DEPTH + 1);

    localparam int CLASS_ID_W  = 3;
    localparam int ACCOUNT_W   = 31;
    localparam int OPS_W       = 16;
    localparam int QUOTA_W     = 8;
    localparam int TIME_W      = 32;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_QUOTA_BASE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIME_PER_OP = 3'd5;

    localparam logic REQ_ENQUEUE = 1'b0;
    localparam logic REQ_SERVE   = 1'b1;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_CLASS = 2'd1,
        ST_FULL      = 2'd2,
        ST_NONE      = 2'd3
    } t_status;

    typedef struct packed {
        logic [ACCOUNT_W-1:0] account;
        logic [OPS_W-1:0]     ops;
    } t_entry;

    typedef logic [NUM_CLASSES-1:0][QUOTA_W-1:0] t_quota;

    typedef struct packed {
        logic             found;
        logic [CLS_W-1:0] idx;
    } t_pick;

    function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] slot);
        logic [SLOT_W-1:0] res;
        if (slot == SLOT_W'(QUEUE_DEPTH - 1)) begin
            res = '0;
        end else begin
            res = slot + SLOT_W'(1);
        end
        return res;
    endfunction

    function automatic logic [ADDR_W-1:0] mem_addr(input logic [CLS_W-1:0] cls,
                                                   input logic [SLOT_W-1:0] slot);
        return ADDR_W'(int'(cls) * QUEUE_DEPTH + int'(slot));
    endfunction

    // Current class keeps its running count; every other class, and the
    // current one once the scan wraps back to it, starts a fresh round.
    function automatic t_pick pick_class(input logic [NUM_CLASSES-1:0] nonempty,
                                         input t_quota quota,
                                         input logic [CLS_W-1:0] cur,
                                         input logic [QUOTA_W-1:0] used);
        t_pick res;
        int    j;
        res = '0;
        for (int k = NUM_CLASSES; k >= 1; k--) begin
            j = int'(cur) + k;
            if (j >= NUM_CLASSES) begin
                j = j - NUM_CLASSES;
            end
            if (nonempty[j] && quota[j] != '0) begin
                res.found = 1'b1;
                res.idx   = CLS_W'(j);
            end
        end
        if (nonempty[cur] && used < quota[cur]) begin
            res.found = 1'b1;
            res.idx   = cur;
        end
        return res;
    endfunction

endpackage

/* design/weighted_round_robin_class_queues_core.sv */
// Top level: class FIFOs with a weighted round-robin server.
// Depends on wrr_pkg.
//
// One transaction is taken in every cycle (busy stays low) and its result
// appears on the o_ ports with o_valid after the input and output registers,
// for exactly one cycle; the receiver cannot stall, so it must take every
// result as it comes. Each class keeps its first two entries in registers and
// the rest in a shared entry memory; a pop refills the second slot from that
// memory through a registered read, which the bypass on the memory read data
// covers, so pops of the same class may follow back to back. A serve that
// finds no non-empty class with quota left reports status 3 and changes
// nothing. Configuration writes are taken at any edge with i_cfg_we high;
// write them only while no transaction is in flight.
module weighted_round_robin_class_queues_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic                               i_req_type,
    input  logic [wrr_pkg::CLASS_ID_W-1:0]     i_class_id,
    input  logic [wrr_pkg::ACCOUNT_W-1:0]      i_account,
    input  logic [wrr_pkg::OPS_W-1:0]          i_op_count,
    input  logic                               i_cfg_we,
    input  logic [wrr_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [wrr_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    output logic                               o_valid,
    output logic [1:0]                         o_status,
    output logic [wrr_pkg::ACCOUNT_W-1:0]      o_served_account,
    output logic [wrr_pkg::OPS_W-1:0]          o_served_ops,
    output logic [wrr_pkg::CLASS_ID_W-1:0]     o_served_class,
    output logic [wrr_pkg::TIME_W-1:0]         o_service_time,
    output logic [wrr_pkg::TOT_W-1:0]          o_total_waiting,
    output logic [wrr_pkg::CLASS_ID_W-1:0]     o_peek_class,
    output logic [wrr_pkg::ACCOUNT_W-1:0]      o_peek_account,
    output logic [wrr_pkg::OPS_W-1:0]          o_peek_ops
);

    localparam int NC = wrr_pkg::NUM_CLASSES;

    wrr_pkg::t_entry                    mem [wrr_pkg::MEM_DEPTH];

    // input register
    logic                               r_in_vld;
    logic                               r_in_req;
    logic [wrr_pkg::CLASS_ID_W-1:0]     r_in_cls;
    wrr_pkg::t_entry                    r_in_data;

    // queue state
    logic [wrr_pkg::CNT_W-1:0]          r_cnt  [NC];
    logic [wrr_pkg::CNT_W-1:0]          n_cnt  [NC];
    logic [wrr_pkg::SLOT_W-1:0]         r_head [NC];
    logic [wrr_pkg::SLOT_W-1:0]         n_head [NC];
    logic [wrr_pkg::SLOT_W-1:0]         r_tail [NC];
    logic [wrr_pkg::SLOT_W-1:0]         n_tail [NC];
    wrr_pkg::t_entry                    r_c0   [NC];
    wrr_pkg::t_entry                    n_c0   [NC];
    wrr_pkg::t_entry                    r_c1   [NC];
    wrr_pkg::t_entry                    n_c1   [NC];
    wrr_pkg::t_entry                    eff_c1 [NC];
    logic                               r_fill_vld;
    logic                               n_fill_vld;
    logic [wrr_pkg::CLS_W-1:0]          r_fill_idx;
    logic [wrr_pkg::CLS_W-1:0]          n_fill_idx;
    wrr_pkg::t_entry                    r_rd_data;
    logic [wrr_pkg::CLS_W-1:0]          r_cur;
    logic [wrr_pkg::CLS_W-1:0]          n_cur;
    logic [wrr_pkg::QUOTA_W-1:0]        r_used;
    logic [wrr_pkg::QUOTA_W-1:0]        n_used;
    logic [wrr_pkg::TOT_W-1:0]          r_total;
    logic [wrr_pkg::TOT_W-1:0]          n_total;
    wrr_pkg::t_quota                    r_quota;
    logic [wrr_pkg::OPS_W-1:0]          r_tpo;

    // step logic
    logic [NC-1:0]                      nonempty;
    logic [NC-1:0]                      n_nonempty;
    wrr_pkg::t_pick                     srv;
    wrr_pkg::t_pick                     pk;
    logic [wrr_pkg::CLS_W-1:0]          enq_idx;
    logic                               mem_we;
    logic [wrr_pkg::ADDR_W-1:0]         wr_addr;
    logic [wrr_pkg::ADDR_W-1:0]         rd_addr;
    wrr_pkg::t_status                   status;
    wrr_pkg::t_entry                    served;
    logic [wrr_pkg::CLASS_ID_W-1:0]     served_cls;
    logic [wrr_pkg::TIME_W-1:0]         svc_time;
    wrr_pkg::t_entry                    peek;
    logic [wrr_pkg::CLASS_ID_W-1:0]     peek_cls;

    assign busy = 1'b0;

    always_comb begin
        for (int c = 0; c < NC; c++) begin
            eff_c1[c]   = (r_fill_vld && r_fill_idx == wrr_pkg::CLS_W'(c)) ? r_rd_data
                                                                           : r_c1[c];
            nonempty[c] = (r_cnt[c] != '0);
        end
    end

    assign srv     = wrr_pkg::pick_class(nonempty, r_quota, r_cur, r_used);
    assign enq_idx = wrr_pkg::CLS_W'(r_in_cls - wrr_pkg::CLASS_ID_W'(1));

    always_comb begin
        for (int c = 0; c < NC; c++) begin
            n_cnt[c]  = r_cnt[c];
            n_head[c] = r_head[c];
            n_tail[c] = r_tail[c];
            n_c0[c]   = r_c0[c];
            n_c1[c]   = eff_c1[c];
        end
        n_fill_vld = 1'b0;
        n_fill_idx = r_fill_idx;
        n_cur      = r_cur;
        n_used     = r_used;
        n_total    = r_total;
        mem_we     = 1'b0;
        wr_addr    = wrr_pkg::mem_addr(enq_idx, r_tail[enq_idx]);
        rd_addr    = wrr_pkg::mem_addr(srv.idx,
                         wrr_pkg::slot_inc(wrr_pkg::slot_inc(r_head[srv.idx])));
        status     = wrr_pkg::ST_OK;
        served     = '0;
        served_cls = '0;
        svc_time   = '0;

        if (r_in_req == wrr_pkg::REQ_ENQUEUE) begin
            if (r_in_cls == '0 || r_in_cls > wrr_pkg::CLASS_ID_W'(NC)) begin
                status = wrr_pkg::ST_BAD_CLASS;
            end else if (r_cnt[enq_idx] == wrr_pkg::CNT_W'(wrr_pkg::QUEUE_DEPTH)) begin
                status = wrr_pkg::ST_FULL;
            end else begin
                mem_we          = r_in_vld;
                n_tail[enq_idx] = wrr_pkg::slot_inc(r_tail[enq_idx]);
                n_cnt[enq_idx]  = r_cnt[enq_idx] + wrr_pkg::CNT_W'(1);
                n_total         = r_total + wrr_pkg::TOT_W'(1);
                if (r_cnt[enq_idx] == wrr_pkg::CNT_W'(0)) begin
                    n_c0[enq_idx] = r_in_data;
                end
                if (r_cnt[enq_idx] == wrr_pkg::CNT_W'(1)) begin
                    n_c1[enq_idx] = r_in_data;
                end
            end
        end else begin
            if (!srv.found) begin
                status = wrr_pkg::ST_NONE;
            end else begin
                served          = r_c0[srv.idx];
                served_cls      = wrr_pkg::CLASS_ID_W'(int'(srv.idx) + 1);
                svc_time        = {16'b0, served.ops} * {16'b0, r_tpo};
                n_c0[srv.idx]   = eff_c1[srv.idx];
                n_head[srv.idx] = wrr_pkg::slot_inc(r_head[srv.idx]);
                n_cnt[srv.idx]  = r_cnt[srv.idx] - wrr_pkg::CNT_W'(1);
                n_total         = r_total - wrr_pkg::TOT_W'(1);
                n_cur           = srv.idx;
                n_used          = ((srv.idx != r_cur) ? '0 : r_used)
                                  + wrr_pkg::QUOTA_W'(1);
                if (r_cnt[srv.idx] >= wrr_pkg::CNT_W'(3)) begin
                    n_fill_vld = 1'b1;
                    n_fill_idx = srv.idx;
                end
            end
        end

        // drop the state changes (but r_c1 and the fill index) when no transaction is in the input register
        if (!r_in_vld) begin
            for (int c = 0; c < NC; c++) begin
                n_cnt[c]  = r_cnt[c];
                n_head[c] = r_head[c];
                n_tail[c] = r_tail[c];
                n_c0[c]   = r_c0[c];
            end
            n_fill_vld = 1'b0;
            n_cur      = r_cur;
            n_used     = r_used;
            n_total    = r_total;
        end
    end

    always_comb begin
        for (int c = 0; c < NC; c++) begin
            n_nonempty[c] = (n_cnt[c] != '0);
        end
    end

    assign pk       = wrr_pkg::pick_class(n_nonempty, r_quota, n_cur, n_used);
    assign peek     = pk.found ? n_c0[pk.idx] : '0;
    assign peek_cls = pk.found ? wrr_pkg::CLASS_ID_W'(int'(pk.idx) + 1) : '0;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[wr_addr] <= r_in_data;
        end
        r_rd_data <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld   <= 1'b0;
            o_valid    <= 1'b0;
            r_fill_vld <= 1'b0;
            r_fill_idx <= '0;
            r_cur      <= '0;
            r_used     <= '0;
            r_total    <= '0;
            r_tpo      <= wrr_pkg::OPS_W'(1);
            for (int c = 0; c < NC; c++) begin
                r_cnt[c]   <= '0;
                r_head[c]  <= '0;
                r_tail[c]  <= '0;
                r_quota[c] <= wrr_pkg::QUOTA_W'(1);
            end
        end else begin
            r_in_vld   <= start;
            o_valid    <= r_in_vld;
            r_fill_vld <= n_fill_vld;
            r_fill_idx <= n_fill_idx;
            r_cur      <= n_cur;
            r_used     <= n_used;
            r_total    <= n_total;
            for (int c = 0; c < NC; c++) begin
                r_cnt[c]  <= n_cnt[c];
                r_head[c] <= n_head[c];
                r_tail[c] <= n_tail[c];
            end
            if (i_cfg_we) begin
                if (i_cfg_idx == wrr_pkg::CFG_TIME_PER_OP) begin
                    r_tpo <= i_cfg_data;
                end
                for (int c = 0; c < NC; c++) begin
                    if (i_cfg_idx == wrr_pkg::CFG_IDX_W'(int'(wrr_pkg::CFG_QUOTA_BASE) + c))
                    begin
                        r_quota[c] <= i_cfg_data[wrr_pkg::QUOTA_W-1:0];
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_in_req         <= i_req_type;
        r_in_cls         <= i_class_id;
        r_in_data        <= '{account: i_account, ops: i_op_count};
        for (int c = 0; c < NC; c++) begin
            r_c0[c] <= n_c0[c];
            r_c1[c] <= n_c1[c];
        end
        o_status         <= status;
        o_served_account <= served.account;
        o_served_ops     <= served.ops;
        o_served_class   <= served_cls;
        o_service_time   <= svc_time;
        o_total_waiting  <= n_total;
        o_peek_class     <= peek_cls;
        o_peek_account   <= peek.account;
        o_peek_ops       <= peek.ops;
    end

endmodule

/* tb/tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench for weighted_round_robin_class_queues_core: class FIFO
// enqueue and weighted round-robin serve, checked against an in-bench scheduler.
// Depends on wrr_pkg and the core RTL only.
module tb;

    localparam int WATCHDOG_LIMIT = 2000;

    typedef struct packed {
        logic                           req_type;
        logic [wrr_pkg::CLASS_ID_W-1:0] class_id;
        logic [wrr_pkg::ACCOUNT_W-1:0]  account;
        logic [wrr_pkg::OPS_W-1:0]      op_count;
    } t_request;

    typedef struct packed {
        wrr_pkg::t_status               status;
        logic [wrr_pkg::ACCOUNT_W-1:0]  served_account;
        logic [wrr_pkg::OPS_W-1:0]      served_ops;
        logic [wrr_pkg::CLASS_ID_W-1:0] served_class;
        logic [wrr_pkg::TIME_W-1:0]     service_time;
        logic [wrr_pkg::TOT_W-1:0]      total_waiting;
        logic [wrr_pkg::CLASS_ID_W-1:0] peek_class;
        logic [wrr_pkg::ACCOUNT_W-1:0]  peek_account;
        logic [wrr_pkg::OPS_W-1:0]      peek_ops;
    } t_outcome;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           start = 1'b0;
    logic                           busy;
    logic                           i_req_type = 1'b0;
    logic [wrr_pkg::CLASS_ID_W-1:0] i_class_id = '0;
    logic [wrr_pkg::ACCOUNT_W-1:0]  i_account = '0;
    logic [wrr_pkg::OPS_W-1:0]      i_op_count = '0;
    logic                           i_cfg_we = 1'b0;
    logic [wrr_pkg::CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [wrr_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                           o_valid;
    logic [1:0]                     o_status;
    logic [wrr_pkg::ACCOUNT_W-1:0]  o_served_account;
    logic [wrr_pkg::OPS_W-1:0]      o_served_ops;
    logic [wrr_pkg::CLASS_ID_W-1:0] o_served_class;
    logic [wrr_pkg::TIME_W-1:0]     o_service_time;
    logic [wrr_pkg::TOT_W-1:0]      o_total_waiting;
    logic [wrr_pkg::CLASS_ID_W-1:0] o_peek_class;
    logic [wrr_pkg::ACCOUNT_W-1:0]  o_peek_account;
    logic [wrr_pkg::OPS_W-1:0]      o_peek_ops;

    weighted_round_robin_class_queues_core i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_req_type       (i_req_type),
        .i_class_id       (i_class_id),
        .i_account        (i_account),
        .i_op_count       (i_op_count),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .o_valid          (o_valid),
        .o_status         (o_status),
        .o_served_account (o_served_account),
        .o_served_ops     (o_served_ops),
        .o_served_class   (o_served_class),
        .o_service_time   (o_service_time),
        .o_total_waiting  (o_total_waiting),
        .o_peek_class     (o_peek_class),
        .o_peek_account   (o_peek_account),
        .o_peek_ops       (o_peek_ops)
    );

    always #5 i_clk = ~i_clk;

    // scheduler state
    wrr_pkg::t_entry entry_store [wrr_pkg::NUM_CLASSES][wrr_pkg::QUEUE_DEPTH];
    int unsigned     q_head [wrr_pkg::NUM_CLASSES];
    int unsigned     q_tail [wrr_pkg::NUM_CLASSES];
    int unsigned     q_count [wrr_pkg::NUM_CLASSES];
    int unsigned     cur_class;
    logic [7:0]      round_used;
    logic [wrr_pkg::QUOTA_W-1:0] class_quota [wrr_pkg::NUM_CLASSES];
    logic [wrr_pkg::OPS_W-1:0]   time_per_op;

    t_request        request_q[$];
    t_outcome        predicted_outcomes[$];
    t_request        seen_req;
    t_outcome        due;
    int              sender_idle_pct = 31;
    logic            took = 1'b0;
    int              errors = 0;
    int              stall_cycles = 0;
    int              n_accepted = 0;
    int              status_seen [4];

    function automatic int unsigned eligible_class();
        int unsigned c;
        int unsigned used;
        int unsigned res;
        c = cur_class;
        used = round_used;
        res = 0;
        if (c < 1 || c > wrr_pkg::NUM_CLASSES) begin
            c = 1;
        end
        for (int i = 0; i <= wrr_pkg::NUM_CLASSES && res == 0; i++) begin
            if (q_count[c-1] > 0 && used < class_quota[c-1]) begin
                res = c;
            end else begin
                c = (c >= wrr_pkg::NUM_CLASSES) ? 1 : c + 1;
                used = 0;
            end
        end
        return res;
    endfunction

    function automatic t_outcome schedule_item(input t_request r);
        t_outcome    res;
        int unsigned c;
        int unsigned q;
        int unsigned total;
        res = '0;
        res.status = wrr_pkg::ST_OK;
        if (r.req_type == wrr_pkg::REQ_ENQUEUE) begin
            if (r.class_id < 1 || r.class_id > wrr_pkg::NUM_CLASSES) begin
                res.status = wrr_pkg::ST_BAD_CLASS;
            end else if (q_count[r.class_id-1] >= wrr_pkg::QUEUE_DEPTH) begin
                res.status = wrr_pkg::ST_FULL;
            end else begin
                q = r.class_id - 1;
                entry_store[q][q_tail[q]] = '{account: r.account, ops: r.op_count};
                q_tail[q] = (q_tail[q] + 1) % wrr_pkg::QUEUE_DEPTH;
                q_count[q]++;
            end
        end else begin
            c = eligible_class();
            if (c == 0) begin
                res.status = wrr_pkg::ST_NONE;
            end else begin
                q = c - 1;
                if (c != cur_class) begin
                    round_used = '0;
                end
                cur_class = c;
                round_used = round_used + 8'd1;
                res.served_account = entry_store[q][q_head[q]].account;
                res.served_ops     = entry_store[q][q_head[q]].ops;
                res.served_class   = wrr_pkg::CLASS_ID_W'(c);
                res.service_time   = wrr_pkg::TIME_W'(res.served_ops)
                                     * wrr_pkg::TIME_W'(time_per_op);
                q_head[q] = (q_head[q] + 1) % wrr_pkg::QUEUE_DEPTH;
                q_count[q]--;
            end
        end
        total = 0;
        for (int k = 0; k < wrr_pkg::NUM_CLASSES; k++) begin
            total += q_count[k];
        end
        res.total_waiting = wrr_pkg::TOT_W'(total);
        c = eligible_class();
        if (c != 0) begin
            res.peek_class   = wrr_pkg::CLASS_ID_W'(c);
            res.peek_account = entry_store[c-1][q_head[c-1]].account;
            res.peek_ops     = entry_store[c-1][q_head[c-1]].ops;
        end
        return res;
    endfunction

    function automatic int field_diff(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
        if (want !== got) begin
            $display("%0t ns: %s expected 0x%0h got 0x%0h", $time, name, want, got);
            return 1;
        end
        return 0;
    endfunction

    // driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (!start || took) begin
            if (request_q.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
                seen_req = request_q.pop_front();
                i_req_type <= seen_req.req_type;
                i_class_id <= seen_req.class_id;
                i_account  <= seen_req.account;
                i_op_count <= seen_req.op_count;
                start      <= 1'b1;
            end else begin
                start <= 1'b0;
            end
        end
    end

    // monitor: predict on acceptance, check each strobed result
    always @(posedge i_clk) begin
        took <= i_rst_n && start && !busy;
        if (i_rst_n && start && !busy) begin
            predicted_outcomes.push_back(schedule_item(
                '{req_type: i_req_type, class_id: i_class_id,
                  account: i_account, op_count: i_op_count}));
            n_accepted++;
        end
        if (i_rst_n && o_valid) begin
            if (predicted_outcomes.size() == 0) begin
                $display("%0t ns: result with none expected, status %0d", $time, o_status);
                errors++;
            end else begin
                due = predicted_outcomes.pop_front();
                status_seen[due.status]++;
                errors += field_diff("status", 32'(due.status), 32'(o_status));
                errors += field_diff("served_account", 32'(due.served_account),
                                     32'(o_served_account));
                errors += field_diff("served_ops", 32'(due.served_ops), 32'(o_served_ops));
                errors += field_diff("served_class", 32'(due.served_class),
                                     32'(o_served_class));
                errors += field_diff("service_time", due.service_time, o_service_time);
                errors += field_diff("total_waiting", 32'(due.total_waiting),
                                     32'(o_total_waiting));
                errors += field_diff("peek_class", 32'(due.peek_class), 32'(o_peek_class));
                errors += field_diff("peek_account", 32'(due.peek_account),
                                     32'(o_peek_account));
                errors += field_diff("peek_ops", 32'(due.peek_ops), 32'(o_peek_ops));
            end
        end
        if ((start && !busy) || o_valid) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", stall_cycles);
            $display("tb NOT OK");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic write_reg(input logic [wrr_pkg::CFG_IDX_W-1:0] idx,
                             input logic [wrr_pkg::CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        if (idx < wrr_pkg::CFG_TIME_PER_OP) begin
            class_quota[idx - wrr_pkg::CFG_QUOTA_BASE] = data[wrr_pkg::QUOTA_W-1:0];
        end else if (idx == wrr_pkg::CFG_TIME_PER_OP) begin
            time_per_op = data;
        end
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_quota(input int cls, input int quota);
        write_reg(wrr_pkg::CFG_IDX_W'(wrr_pkg::CFG_QUOTA_BASE + cls),
                  {8'($urandom), 8'(quota)});
    endtask

    task automatic add_item(input logic req, input int cls,
                            input logic [wrr_pkg::ACCOUNT_W-1:0] acct,
                            input logic [wrr_pkg::OPS_W-1:0] ops);
        request_q.push_back('{req_type: req, class_id: wrr_pkg::CLASS_ID_W'(cls),
                              account: acct, op_count: ops});
    endtask

    // hold until nothing is pending or in flight, then let the pipeline settle
    task automatic drain();
        while (request_q.size() > 0 || start || predicted_outcomes.size() > 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    // bursts of fill, drain or mixed traffic, mostly aimed at one class per burst
    task automatic queue_random(input int n);
        int left;
        int len;
        int enq_pct;
        int focus;
        int pick;
        int cls;
        logic [wrr_pkg::ACCOUNT_W-1:0] acct;
        logic [wrr_pkg::OPS_W-1:0] ops;
        left = n;
        while (left > 0) begin
            len = $urandom_range(60, 8);
            if (len > left) begin
                len = left;
            end
            case ($urandom_range(2))
                0: enq_pct = 85;
                1: enq_pct = 15;
                default: enq_pct = 50;
            endcase
            focus = $urandom_range(wrr_pkg::NUM_CLASSES, 1);
            for (int k = 0; k < len; k++) begin
                pick = $urandom_range(99);
                if (pick < 8) begin
                    cls = $urandom_range(1) ? 0 : $urandom_range(7, wrr_pkg::NUM_CLASSES + 1);
                end else if (pick < 65) begin
                    cls = focus;
                end else begin
                    cls = $urandom_range(wrr_pkg::NUM_CLASSES, 1);
                end
                case ($urandom_range(9))
                    0: acct = '0;
                    1: acct = '1;
                    default: acct = wrr_pkg::ACCOUNT_W'($urandom);
                endcase
                case ($urandom_range(9))
                    0: ops = '0;
                    1: ops = '1;
                    default: ops = wrr_pkg::OPS_W'($urandom);
                endcase
                add_item(($urandom_range(99) < enq_pct) ? wrr_pkg::REQ_ENQUEUE
                                                        : wrr_pkg::REQ_SERVE,
                         cls, acct, ops);
            end
            left -= len;
        end
    endtask

    initial begin
        for (int c = 0; c < wrr_pkg::NUM_CLASSES; c++) begin
            q_head[c] = 0;
            q_tail[c] = 0;
            q_count[c] = 0;
            class_quota[c] = 8'd1;
            for (int s = 0; s < wrr_pkg::QUEUE_DEPTH; s++) begin
                entry_store[c][s] = '0;
            end
        end
        for (int s = 0; s < 4; s++) begin
            status_seen[s] = 0;
        end
        cur_class = 1;
        round_used = '0;
        time_per_op = 16'd1;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        set_quota(0, 255);
        set_quota(1, 1);
        set_quota(2, 1);
        set_quota(3, 0);
        set_quota(4, 1);
        write_reg(wrr_pkg::CFG_TIME_PER_OP, 16'hFFFF);
        for (int r = wrr_pkg::CFG_TIME_PER_OP + 1; r < 2 ** wrr_pkg::CFG_IDX_W; r++) begin
            write_reg(wrr_pkg::CFG_IDX_W'(r), 16'h0000);
        end

        add_item(wrr_pkg::REQ_SERVE, 3, '1, '1);
        add_item(wrr_pkg::REQ_ENQUEUE, 0, wrr_pkg::ACCOUNT_W'($urandom),
                 wrr_pkg::OPS_W'($urandom));
        add_item(wrr_pkg::REQ_ENQUEUE, 6, wrr_pkg::ACCOUNT_W'($urandom),
                 wrr_pkg::OPS_W'($urandom));
        add_item(wrr_pkg::REQ_ENQUEUE, 7, '1, '1);
        add_item(wrr_pkg::REQ_ENQUEUE, 4, wrr_pkg::ACCOUNT_W'($urandom),
                 wrr_pkg::OPS_W'($urandom));
        add_item(wrr_pkg::REQ_SERVE, 0, '0, '0);
        add_item(wrr_pkg::REQ_ENQUEUE, 1, '1, '1);
        add_item(wrr_pkg::REQ_ENQUEUE, 1, '0, '0);
        add_item(wrr_pkg::REQ_ENQUEUE, 2, wrr_pkg::ACCOUNT_W'($urandom),
                 wrr_pkg::OPS_W'($urandom));
        add_item(wrr_pkg::REQ_ENQUEUE, 3, wrr_pkg::ACCOUNT_W'($urandom),
                 wrr_pkg::OPS_W'($urandom));
        add_item(wrr_pkg::REQ_ENQUEUE, 5, wrr_pkg::ACCOUNT_W'($urandom),
                 wrr_pkg::OPS_W'($urandom));
        for (int k = 0; k < 6; k++) begin
            add_item(wrr_pkg::REQ_SERVE, $urandom_range(7), wrr_pkg::ACCOUNT_W'($urandom),
                     wrr_pkg::OPS_W'($urandom));
        end
        drain();

        for (int c = 0; c < wrr_pkg::NUM_CLASSES; c++) begin
            set_quota(c, 1);
        end
        write_reg(wrr_pkg::CFG_TIME_PER_OP, 16'd1);
        queue_random(350);
        drain();

        for (int c = 0; c < wrr_pkg::NUM_CLASSES; c++) begin
            set_quota(c, $urandom_range(4));
        end
        write_reg(wrr_pkg::CFG_TIME_PER_OP, wrr_pkg::CFG_DATA_W'($urandom));
        queue_random(350);
        drain();

        sender_idle_pct = 81;
        for (int c = 0; c < wrr_pkg::NUM_CLASSES; c++) begin
            set_quota(c, 255);
        end
        write_reg(wrr_pkg::CFG_TIME_PER_OP, 16'd0);
        queue_random(200);
        drain();

        for (int c = 0; c < wrr_pkg::NUM_CLASSES; c++) begin
            set_quota(c, 0);
        end
        set_quota($urandom_range(wrr_pkg::NUM_CLASSES - 1), 2);
        write_reg(wrr_pkg::CFG_TIME_PER_OP, 16'hFFFF);
        queue_random(200);
        drain();

        sender_idle_pct = 0;
        for (int c = 0; c < wrr_pkg::NUM_CLASSES; c++) begin
            set_quota(c, $urandom_range(8, 1));
        end
        write_reg(wrr_pkg::CFG_TIME_PER_OP, wrr_pkg::CFG_DATA_W'($urandom));
        queue_random(450);
        drain();
        repeat (8) @(posedge i_clk);

        $display("run covered %0d transactions over six register settings", n_accepted);
        $display("results: %0d ok, %0d bad class, %0d queue full, %0d nothing to serve",
                 status_seen[wrr_pkg::ST_OK], status_seen[wrr_pkg::ST_BAD_CLASS],
                 status_seen[wrr_pkg::ST_FULL], status_seen[wrr_pkg::ST_NONE]);
        if (errors == 0 && predicted_outcomes.size() == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule

/* files.f */
design/wrr_pkg.sv
design/weighted_round_robin_class_queues_core.sv
tb/tb.sv
